// ----- design/etf_pkg.sv -----
// Shared types, constants and helpers for the escape-time pixel engine.
`timescale 1ns / 1ps
`default_nettype none

package etf_pkg;

  localparam int FRAME_WIDTH  = 1024;
  localparam int FRAME_HEIGHT = 1024;

  localparam int COL_W     = 10;
  localparam int ROW_W     = 10;
  localparam int ITER_W    = 16;
  localparam int SCALE_W   = 27;
  localparam int Q_W       = 32;
  localparam int FRAC_BITS = 26;
  localparam int PROD_W    = 2 * Q_W;
  localparam int ZSQ_W     = 40;
  localparam int SUM_W     = PROD_W + 2;
  localparam int HALF_S    = 27;
  localparam int ACC_W     = 112;
  localparam int CFG_IDX_W = 3;

  localparam logic signed [Q_W-1:0] COL_OFS   = Q_W'(FRAME_WIDTH / 2);
  localparam logic signed [Q_W-1:0] ROW_OFS_J = Q_W'(FRAME_HEIGHT / 4);
  localparam logic signed [Q_W-1:0] ROW_OFS_M = Q_W'(3 * FRAME_HEIGHT / 4);
  localparam logic [Q_W-1:0]        JULIA_ROWS = Q_W'(FRAME_HEIGHT / 2);

  localparam logic signed [Q_W-1:0]   ONE_Q  = Q_W'(1 << FRAC_BITS);
  localparam logic signed [Q_W-1:0]   QTR_Q  = Q_W'(1 << (FRAC_BITS - 2));
  localparam logic signed [Q_W-1:0]   LIM_Q  = Q_W'(2 << FRAC_BITS);
  localparam logic signed [ZSQ_W-1:0] FOUR_Q = ZSQ_W'(4 << FRAC_BITS);
  localparam logic [PROD_W-1:0]       BULB_LIM = PROD_W'(1) << (2 * FRAC_BITS - 4);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_MAX_ITER     = 3'd0,
    REG_SCALE_MANDEL = 3'd1,
    REG_SCALE_JULIA  = 3'd2,
    REG_C_REAL       = 3'd3,
    REG_C_IMAG       = 3'd4,
    REG_START_REAL   = 3'd5,
    REG_START_IMAG   = 3'd6
  } cfg_reg_t;

  typedef struct packed {
    logic [ITER_W-1:0]        iter_limit;
    logic [SCALE_W-1:0]       scale_mandel;
    logic [SCALE_W-1:0]       scale_julia;
    logic signed [Q_W-1:0]    c_real;
    logic signed [Q_W-1:0]    c_imag;
    logic signed [Q_W-1:0]    start_real;
    logic signed [Q_W-1:0]    start_imag;
  } etf_cfg_t;

  typedef struct packed {
    logic              valid;
    logic [ITER_W-1:0] count;
    logic              bounded;
  } etf_res_t;

  function automatic logic signed [Q_W-1:0] sat32(input logic signed [SUM_W-1:0] v);
    if ((&v[SUM_W-1:Q_W-1]) || !(|v[SUM_W-1:Q_W-1])) begin
      return v[Q_W-1:0];
    end else if (v[SUM_W-1]) begin
      return {1'b1, {(Q_W-1){1'b0}}};
    end else begin
      return {1'b0, {(Q_W-1){1'b1}}};
    end
  endfunction

endpackage

`default_nettype wire

// ----- design/etf_mult.sv -----
// Shared signed 32x32 multiplier with a registered product.
`timescale 1ns / 1ps
`default_nettype none

module etf_mult import etf_pkg::*; (
  input  logic                     clk,
  input  logic signed [Q_W-1:0]    op_a,
  input  logic signed [Q_W-1:0]    op_b,
  output logic signed [PROD_W-1:0] prod
);

  logic signed [PROD_W-1:0] prod_r;

  always_ff @(posedge clk) begin
    prod_r <= op_a * op_b;
  end

  assign prod = prod_r;

endmodule

`default_nettype wire

// ----- design/etf_core.sv -----
// Sequencer and datapath: pixel mapping, cardioid/bulb test and z = z^2 + c loop.
`timescale 1ns / 1ps
`default_nettype none

module etf_core import etf_pkg::*; (
  input  logic             clk,
  input  logic             rst_n,
  input  etf_cfg_t         cfg,
  input  logic             start,
  input  logic [COL_W-1:0] col,
  input  logic [ROW_W-1:0] row,
  output logic             idle,
  output etf_res_t         res,
  input  logic             res_ready
);

  typedef enum logic [4:0] {
    ST_IDLE, ST_PX, ST_PY, ST_PZ,
    ST_K_BX, ST_K_YY, ST_K_AA, ST_K_Q, ST_K_S, ST_K_D,
    ST_K_M1, ST_K_M2, ST_K_M3, ST_K_CMP,
    ST_SQX, ST_SQY, ST_CHK, ST_NEWZ, ST_DONE
  } state_t;

  state_t                   state_r;
  logic [COL_W-1:0]         col_r;
  logic [ROW_W-1:0]         row_r;
  logic                     julia_r;
  logic signed [Q_W-1:0]    zx_r, zy_r, cx_r, cy_r;
  logic signed [ZSQ_W-1:0]  zx2_r, zy2_r;
  logic [ITER_W-1:0]        iter_r;
  logic signed [PROD_W-1:0] t_r, yy_r, q_r, s_r;
  logic [ACC_W-1:0]         acc_r;

  logic signed [Q_W-1:0]    mul_a, mul_b;
  logic signed [PROD_W-1:0] prod;
  logic signed [Q_W-1:0]    dcol, drow, scale_sel, hcx, hcy, bx, a_c;
  logic signed [ZSQ_W-1:0]  zsq_c, esc_sum;
  logic signed [Q_W-1:0]    nzx, nzy, pt_x, pt_y;
  logic                     in_rng, bulb_hit, s_le0, s_big, cmp_hit;
  logic [Q_W-1:0]           sh, sl;

  etf_mult u_mult (
    .clk  (clk),
    .op_a (mul_a),
    .op_b (mul_b),
    .prod (prod)
  );

  assign hcx       = cfg.c_real >>> 1;
  assign hcy       = cfg.c_imag >>> 1;
  assign scale_sel = julia_r ? $signed(Q_W'(cfg.scale_julia)) : $signed(Q_W'(cfg.scale_mandel));
  assign dcol      = $signed(Q_W'(col_r)) - COL_OFS;
  assign drow      = $signed(Q_W'(row_r)) - (julia_r ? ROW_OFS_J : ROW_OFS_M);
  assign bx        = cx_r + ONE_Q;
  assign a_c       = cx_r - QTR_Q;
  assign sh        = Q_W'(s_r[2*HALF_S-1:HALF_S]);
  assign sl        = Q_W'(s_r[HALF_S-1:0]);

  assign pt_x = sat32(SUM_W'(prod) + SUM_W'(julia_r ? cfg.start_real : hcx));
  assign pt_y = sat32(SUM_W'(prod) + SUM_W'(julia_r ? cfg.start_imag : hcy));

  assign zsq_c   = ZSQ_W'(prod >>> FRAC_BITS);
  assign esc_sum = zx2_r + zsq_c;
  assign nzx     = sat32(SUM_W'(zx2_r) - SUM_W'(zy2_r) + SUM_W'(cx_r));
  assign nzy     = sat32(SUM_W'(prod >>> (FRAC_BITS - 1)) + SUM_W'(cy_r));

  assign in_rng   = (cx_r > -LIM_Q) && (cx_r < LIM_Q) && (cy_r > -LIM_Q) && (cy_r < LIM_Q);
  assign bulb_hit = ($unsigned(t_r) + $unsigned(prod)) < BULB_LIM;
  assign s_le0    = s_r[PROD_W-1] || (s_r == '0);
  assign s_big    = |s_r[PROD_W-1:2*HALF_S];
  assign cmp_hit  = acc_r < {q_r[ACC_W-2*FRAC_BITS-1:0], {(2*FRAC_BITS){1'b0}}};

  always_comb begin
    mul_a = '0;
    mul_b = '0;
    unique case (state_r)
      ST_PX:   begin mul_a = dcol;             mul_b = scale_sel;        end
      ST_PY:   begin mul_a = drow;             mul_b = scale_sel;        end
      ST_K_BX: begin mul_a = bx;               mul_b = bx;               end
      ST_K_YY: begin mul_a = cy_r;             mul_b = cy_r;             end
      ST_K_AA: begin mul_a = a_c;              mul_b = a_c;              end
      ST_K_D:  begin mul_a = $signed(sh);      mul_b = $signed(sh);      end
      ST_K_M1: begin mul_a = $signed(sh);      mul_b = $signed(sl);      end
      ST_K_M2: begin mul_a = $signed(sl);      mul_b = $signed(sl);      end
      ST_SQX:  begin mul_a = zx_r;             mul_b = zx_r;             end
      ST_SQY:  begin mul_a = zy_r;             mul_b = zy_r;             end
      ST_CHK:  begin mul_a = zx_r;             mul_b = zy_r;             end
      default: begin mul_a = '0;               mul_b = '0;               end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      unique case (state_r)
        ST_IDLE: begin
          if (start) begin
            col_r   <= col;
            row_r   <= row;
            julia_r <= Q_W'(row) < JULIA_ROWS;
            iter_r  <= '0;
            state_r <= ST_PX;
          end
        end
        ST_PX: state_r <= ST_PY;
        ST_PY: begin
          if (julia_r) begin
            zx_r <= pt_x;
          end else begin
            cx_r <= pt_x;
          end
          state_r <= ST_PZ;
        end
        ST_PZ: begin
          if (julia_r) begin
            zy_r    <= pt_y;
            cx_r    <= hcx;
            cy_r    <= hcy;
            state_r <= ST_SQX;
          end else begin
            cy_r    <= pt_y;
            zx_r    <= cfg.start_real;
            zy_r    <= cfg.start_imag;
            state_r <= ST_K_BX;
          end
        end
        ST_K_BX: state_r <= in_rng ? ST_K_YY : ST_SQX;
        ST_K_YY: begin
          t_r     <= prod;
          state_r <= ST_K_AA;
        end
        ST_K_AA: begin
          yy_r <= prod;
          if (bulb_hit) begin
            iter_r  <= cfg.iter_limit;
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_K_Q;
          end
        end
        ST_K_Q: begin
          q_r     <= prod + yy_r;
          state_r <= ST_K_S;
        end
        ST_K_S: begin
          s_r     <= (q_r <<< 1) + (PROD_W'(a_c) <<< FRAC_BITS);
          state_r <= ST_K_D;
        end
        ST_K_D: begin
          priority if (s_le0) begin
            if (q_r != '0) begin
              iter_r  <= cfg.iter_limit;
              state_r <= ST_DONE;
            end else begin
              state_r <= ST_SQX;
            end
          end else if (s_big) begin
            state_r <= ST_SQX;
          end else begin
            state_r <= ST_K_M1;
          end
        end
        ST_K_M1: begin
          acc_r   <= {prod[ACC_W-2*HALF_S-1:0], {(2*HALF_S){1'b0}}};
          state_r <= ST_K_M2;
        end
        ST_K_M2: begin
          acc_r   <= acc_r + ACC_W'({prod, {(HALF_S+1){1'b0}}});
          state_r <= ST_K_M3;
        end
        ST_K_M3: begin
          acc_r   <= acc_r + ACC_W'($unsigned(prod));
          state_r <= ST_K_CMP;
        end
        ST_K_CMP: begin
          if (cmp_hit) begin
            iter_r  <= cfg.iter_limit;
            state_r <= ST_DONE;
          end else begin
            state_r <= ST_SQX;
          end
        end
        ST_SQX: state_r <= ST_SQY;
        ST_SQY: begin
          zx2_r   <= zsq_c;
          state_r <= ST_CHK;
        end
        ST_CHK: begin
          zy2_r <= zsq_c;
          if ((iter_r < cfg.iter_limit) && (esc_sum < FOUR_Q)) begin
            state_r <= ST_NEWZ;
          end else begin
            state_r <= ST_DONE;
          end
        end
        ST_NEWZ: begin
          zx_r    <= nzx;
          zy_r    <= nzy;
          iter_r  <= iter_r + 1'b1;
          state_r <= ST_SQX;
        end
        ST_DONE: begin
          if (res_ready) begin
            state_r <= ST_IDLE;
          end
        end
        default: state_r <= ST_IDLE;
      endcase
    end
  end

  assign idle        = (state_r == ST_IDLE);
  assign res.valid   = (state_r == ST_DONE);
  assign res.count   = iter_r;
  assign res.bounded = (iter_r >= cfg.iter_limit);

endmodule

`default_nettype wire

// ----- design/escape_time_fractal_pixel.sv -----
// Top level of the escape-time pixel engine: registers, result register, checks.
//
//   channel  direction  handshake            payload
//   in_      input      in_valid / in_stall  in_pixel_col, in_pixel_row
//   out_     output     out_valid / out_stall out_iteration_count, out_stayed_bounded
//   cfg_     input      cfg_valid / cfg_ready cfg_index, cfg_data
//
// Each result passes through the result register to out_valid once its iterations have
// run; Mandelbrot pixels in range first run the cardioid and bulb test.
// The next pixel is taken only once the result has moved to the result register. The
// single shared 32x32 multiplier serves three products and one z update per iteration.
// Reset is synchronous and restores the register defaults; in_stall high, cfg_ready low.
// The result register holds a finished transaction while the next pixel is taken.
`timescale 1ns / 1ps
`default_nettype none

module escape_time_fractal_pixel import etf_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [COL_W-1:0]     in_pixel_col,
  input  logic [ROW_W-1:0]     in_pixel_row,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [ITER_W-1:0]    out_iteration_count,
  output logic                 out_stayed_bounded,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [Q_W-1:0]       cfg_data
);

  etf_cfg_t          cfg_r;
  etf_res_t          core_res;
  logic              core_idle;
  logic              res_ready;
  logic              res_take;
  logic              out_valid_r;
  logic [ITER_W-1:0] out_count_r;
  logic              out_bounded_r;

  assign cfg_ready = rst_n;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.iter_limit   <= ITER_W'(128);
      cfg_r.scale_mandel <= SCALE_W'(524288);
      cfg_r.scale_julia  <= SCALE_W'(524288);
      cfg_r.c_real       <= '0;
      cfg_r.c_imag       <= '0;
      cfg_r.start_real   <= '0;
      cfg_r.start_imag   <= '0;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        REG_MAX_ITER:     cfg_r.iter_limit   <= cfg_data[ITER_W-1:0];
        REG_SCALE_MANDEL: cfg_r.scale_mandel <= cfg_data[SCALE_W-1:0];
        REG_SCALE_JULIA:  cfg_r.scale_julia  <= cfg_data[SCALE_W-1:0];
        REG_C_REAL:       cfg_r.c_real       <= $signed(cfg_data);
        REG_C_IMAG:       cfg_r.c_imag       <= $signed(cfg_data);
        REG_START_REAL:   cfg_r.start_real   <= $signed(cfg_data);
        REG_START_IMAG:   cfg_r.start_imag   <= $signed(cfg_data);
        default: ;
      endcase
    end
  end

  etf_core u_core (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .start     (in_valid && core_idle),
    .col       (in_pixel_col),
    .row       (in_pixel_row),
    .idle      (core_idle),
    .res       (core_res),
    .res_ready (res_ready)
  );

  assign in_stall  = !rst_n || !core_idle;
  assign res_ready = !out_valid_r || !out_stall;
  assign res_take  = core_res.valid && res_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (res_take) begin
      out_valid_r   <= 1'b1;
      out_count_r   <= core_res.count;
      out_bounded_r <= core_res.bounded;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_iteration_count = out_count_r;
  assign out_stayed_bounded  = out_bounded_r;

`ifndef SYNTHESIS
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("core took a pixel but did not go busy");

  a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    res_take |=> (out_valid && (out_iteration_count == $past(core_res.count))))
    else $error("finished transaction not loaded into result register");

  a_result_drained: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_stall && !res_take) |=> !out_valid)
    else $error("result register did not drain after hand-off");
`endif

endmodule

`default_nettype wire

// ----- dv/tb_escape_time_fractal_pixel.sv -----
// Self-checking testbench for the escape-time pixel engine: directed table, then random settings.
`timescale 1ns / 1ps

module tb_escape_time_fractal_pixel;
  import etf_pkg::*;

  localparam int IDLE_PCT          = 14;
  localparam int RANDOM_SETTINGS   = 8;
  localparam int ITEMS_PER_SETTING = 50;
  localparam int QUIET_SETTING     = 3;
  localparam int TAIL_CYCLES       = 1100;
  localparam int RUN_LIMIT_NS      = 50_000_000;
  localparam int NUM_DIRECTED      = 25;

  localparam logic [CFG_IDX_W-1:0] REG_UNMAPPED = 3'd7;

  localparam longint Q_ONE     = longint'(1) << FRAC_BITS;
  localparam longint ESCAPE_R2 = longint'(4) << FRAC_BITS;
  localparam longint Q_MAX     = 64'sd2147483647;
  localparam longint Q_MIN     = -64'sd2147483648;

  typedef enum logic [2:0] {
    SET_RESET,
    SET_ZERO_LIMIT,
    SET_SATURATE,
    SET_DEEP_LIMIT,
    SET_JULIA_CLASSIC
  } setting_t;

  typedef struct packed {
    logic [ITER_W-1:0] count;
    logic              bounded;
  } pixel_result_t;

  typedef struct packed {
    setting_t          setting;
    logic [COL_W-1:0]  col;
    logic [ROW_W-1:0]  row;
    logic              typed;
    logic [ITER_W-1:0] exp_count;
    logic              exp_bounded;
  } pixel_case_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_stall;
  logic [COL_W-1:0]     in_pixel_col = '0;
  logic [ROW_W-1:0]     in_pixel_row = '0;
  logic                 out_valid;
  logic                 out_stall = 1'b0;
  logic [ITER_W-1:0]    out_iteration_count;
  logic                 out_stayed_bounded;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [Q_W-1:0]       cfg_data = '0;

  logic [ITER_W-1:0]     lim_iter    = ITER_W'(128);
  logic [SCALE_W-1:0]    step_mandel = SCALE_W'(524288);
  logic [SCALE_W-1:0]    step_julia  = SCALE_W'(524288);
  logic signed [Q_W-1:0] c_re  = '0;
  logic signed [Q_W-1:0] c_im  = '0;
  logic signed [Q_W-1:0] z1_re = '0;
  logic signed [Q_W-1:0] z1_im = '0;

  pixel_result_t pending_results[$];
  int            mismatch_count = 0;
  int            idle_pct = IDLE_PCT;

  pixel_case_t directed_cases [NUM_DIRECTED] = '{
    '{SET_RESET,         10'd512,  10'd256,  1'b1, 16'd128,   1'b1},
    '{SET_RESET,         10'd0,    10'd0,    1'b1, 16'd0,     1'b0},
    '{SET_RESET,         10'd1023, 10'd511,  1'b1, 16'd0,     1'b0},
    '{SET_RESET,         10'd512,  10'd768,  1'b1, 16'd128,   1'b1},
    '{SET_RESET,         10'd384,  10'd768,  1'b1, 16'd128,   1'b1},
    '{SET_RESET,         10'd0,    10'd512,  1'b1, 16'd1,     1'b0},
    '{SET_RESET,         10'd1023, 10'd1023, 1'b1, 16'd1,     1'b0},
    '{SET_RESET,         10'd1023, 10'd0,    1'b0, 16'd0,     1'b0},
    '{SET_RESET,         10'd0,    10'd511,  1'b0, 16'd0,     1'b0},
    '{SET_RESET,         10'd511,  10'd512,  1'b0, 16'd0,     1'b0},
    '{SET_ZERO_LIMIT,    10'd512,  10'd256,  1'b1, 16'd0,     1'b1},
    '{SET_ZERO_LIMIT,    10'd512,  10'd768,  1'b1, 16'd0,     1'b1},
    '{SET_ZERO_LIMIT,    10'd1023, 10'd1023, 1'b1, 16'd0,     1'b1},
    '{SET_SATURATE,      10'd0,    10'd0,    1'b0, 16'd0,     1'b0},
    '{SET_SATURATE,      10'd512,  10'd256,  1'b0, 16'd0,     1'b0},
    '{SET_SATURATE,      10'd0,    10'd1023, 1'b0, 16'd0,     1'b0},
    '{SET_SATURATE,      10'd1023, 10'd768,  1'b0, 16'd0,     1'b0},
    '{SET_DEEP_LIMIT,    10'd508,  10'd768,  1'b1, 16'd32768, 1'b1},
    '{SET_DEEP_LIMIT,    10'd507,  10'd768,  1'b1, 16'd32768, 1'b1},
    '{SET_DEEP_LIMIT,    10'd509,  10'd768,  1'b0, 16'd0,     1'b0},
    '{SET_DEEP_LIMIT,    10'd0,    10'd1023, 1'b0, 16'd0,     1'b0},
    '{SET_DEEP_LIMIT,    10'd300,  10'd100,  1'b0, 16'd0,     1'b0},
    '{SET_JULIA_CLASSIC, 10'd512,  10'd256,  1'b0, 16'd0,     1'b0},
    '{SET_JULIA_CLASSIC, 10'd600,  10'd200,  1'b0, 16'd0,     1'b0},
    '{SET_JULIA_CLASSIC, 10'd700,  10'd900,  1'b0, 16'd0,     1'b0}
  };

  escape_time_fractal_pixel u_dut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_pixel_col        (in_pixel_col),
    .in_pixel_row        (in_pixel_row),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_iteration_count (out_iteration_count),
    .out_stayed_bounded  (out_stayed_bounded),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  function automatic longint clamp_q(input longint v);
    if (v > Q_MAX) return Q_MAX;
    if (v < Q_MIN) return Q_MIN;
    return v;
  endfunction

  function automatic bit in_shortcut_region(input longint x, input longint y);
    longint       lim;
    longint       bx;
    longint       a;
    longint       q;
    longint       s;
    logic [127:0] s_sq;
    logic [127:0] q_ext;
    lim = 2 * Q_ONE;
    if (x <= -lim || x >= lim || y <= -lim || y >= lim) return 1'b0;
    bx = x + Q_ONE;
    if (bx * bx + y * y < (longint'(1) << (2 * FRAC_BITS - 4))) return 1'b1;
    a = x - Q_ONE / 4;
    q = a * a + y * y;
    s = 2 * q + a * Q_ONE;
    if (s <= 0) return q > 0;
    s_sq  = 128'(s) * 128'(s);
    q_ext = 128'(q) << 52;
    return s_sq < q_ext;
  endfunction

  function automatic pixel_result_t escape_count(input logic [COL_W-1:0] col,
                                                 input logic [ROW_W-1:0] row);
    longint        dx;
    longint        ry;
    longint        hcx;
    longint        hcy;
    longint        zx;
    longint        zy;
    longint        cx;
    longint        cy;
    longint        zx2;
    longint        zy2;
    longint        nzx;
    longint        nzy;
    int unsigned   iter;
    int unsigned   limit;
    pixel_result_t res;
    iter  = 0;
    limit = 32'(lim_iter);
    hcx   = longint'(c_re) >>> 1;
    hcy   = longint'(c_im) >>> 1;
    dx    = longint'(col) - longint'(FRAME_WIDTH / 2);
    ry    = longint'(row);
    if (ry < longint'(FRAME_HEIGHT / 2)) begin
      zx = clamp_q(dx * longint'(step_julia) + longint'(z1_re));
      zy = clamp_q((ry - longint'(FRAME_HEIGHT / 4)) * longint'(step_julia) + longint'(z1_im));
      cx = hcx;
      cy = hcy;
    end else begin
      cx = clamp_q(dx * longint'(step_mandel) + hcx);
      cy = clamp_q((ry - longint'(3 * FRAME_HEIGHT / 4)) * longint'(step_mandel) + hcy);
      zx = longint'(z1_re);
      zy = longint'(z1_im);
      if (in_shortcut_region(cx, cy)) iter = limit;
    end
    zx2 = (zx * zx) >>> FRAC_BITS;
    zy2 = (zy * zy) >>> FRAC_BITS;
    while (iter < limit && zx2 + zy2 < ESCAPE_R2) begin
      nzy = clamp_q(((zx * zy) >>> (FRAC_BITS - 1)) + cy);
      nzx = clamp_q(zx2 - zy2 + cx);
      zx  = nzx;
      zy  = nzy;
      zx2 = (zx * zx) >>> FRAC_BITS;
      zy2 = (zy * zy) >>> FRAC_BITS;
      iter++;
    end
    res.count   = ITER_W'(iter);
    res.bounded = (iter >= limit);
    return res;
  endfunction

  task automatic report_mismatch(input string msg);
    mismatch_count++;
    if (mismatch_count <= 100) $display("MISMATCH at %0t ns: %s", $time, msg);
  endtask

  always @(posedge clk) begin
    pixel_result_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        report_mismatch($sformatf("transaction with nothing pending: count %0d bounded %0b",
                                  out_iteration_count, out_stayed_bounded));
      end else begin
        want = pending_results.pop_front();
        if (out_iteration_count !== want.count)
          report_mismatch($sformatf("iteration_count %0d, expected %0d",
                                    out_iteration_count, want.count));
        if (out_stayed_bounded !== want.bounded)
          report_mismatch($sformatf("stayed_bounded %0b, expected %0b",
                                    out_stayed_bounded, want.bounded));
      end
    end
    out_stall <= (idle_pct != 0) && ($urandom_range(0, 99) < idle_pct);
  end

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [Q_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_MAX_ITER:     lim_iter    = data[ITER_W-1:0];
      REG_SCALE_MANDEL: step_mandel = data[SCALE_W-1:0];
      REG_SCALE_JULIA:  step_julia  = data[SCALE_W-1:0];
      REG_C_REAL:       c_re        = data;
      REG_C_IMAG:       c_im        = data;
      REG_START_REAL:   z1_re       = data;
      REG_START_IMAG:   z1_im       = data;
      default: ;
    endcase
  endtask

  task automatic apply_setting(input setting_t s);
    case (s)
      SET_ZERO_LIMIT: begin
        write_reg(REG_MAX_ITER, 32'hA5A5_0000);
        write_reg(REG_UNMAPPED, $urandom);
      end
      SET_SATURATE: begin
        write_reg(REG_MAX_ITER, {16'h0F0F, 16'd128});
        write_reg(REG_SCALE_MANDEL, {5'h1F, 27'd1});
        write_reg(REG_SCALE_JULIA, {5'h00, 27'h400_0000});
        write_reg(REG_C_REAL, 32'h8000_0000);
        write_reg(REG_C_IMAG, 32'h7FFF_FFFF);
        write_reg(REG_START_REAL, 32'h7FFF_FFFF);
        write_reg(REG_START_IMAG, 32'h8000_0000);
      end
      SET_DEEP_LIMIT: begin
        write_reg(REG_MAX_ITER, {16'h5A5A, 16'h8000});
        write_reg(REG_SCALE_MANDEL, {5'b10101, 27'h400_0000});
        write_reg(REG_SCALE_JULIA, {5'b01010, 27'd1});
        write_reg(REG_C_REAL, 32'h2000_0000);
        write_reg(REG_C_IMAG, 32'h0000_0000);
        write_reg(REG_START_REAL, 32'h0000_0000);
        write_reg(REG_START_IMAG, 32'h0000_0000);
      end
      SET_JULIA_CLASSIC: begin
        write_reg(REG_MAX_ITER, {16'h0000, 16'd200});
        write_reg(REG_SCALE_MANDEL, {5'h00, 27'd524288});
        write_reg(REG_SCALE_JULIA, {5'h00, 27'd524288});
        write_reg(REG_C_REAL, Q_W'(-107374182));
        write_reg(REG_C_IMAG, Q_W'(20937966));
        write_reg(REG_START_REAL, 32'h0000_0000);
        write_reg(REG_START_IMAG, 32'h0000_0000);
      end
      default: ;
    endcase
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [SCALE_W-1:0] pick_step();
    if ($urandom_range(0, 5) == 0) return SCALE_W'($urandom_range(1, 1 << 26));
    return SCALE_W'($urandom_range(1 << 14, 1 << 21));
  endfunction

  function automatic logic [Q_W-1:0] pick_point(input int unsigned span);
    if ($urandom_range(0, 5) == 0) return $urandom;
    return Q_W'($urandom_range(0, 2 * span)) - Q_W'(span);
  endfunction

  task automatic program_random_setting();
    write_reg(REG_MAX_ITER, {16'($urandom), 16'($urandom_range(128, 256))});
    write_reg(REG_SCALE_MANDEL, {5'($urandom), pick_step()});
    write_reg(REG_SCALE_JULIA, {5'($urandom), pick_step()});
    write_reg(REG_C_REAL, pick_point(1 << 28));
    write_reg(REG_C_IMAG, pick_point(1 << 28));
    write_reg(REG_START_REAL, pick_point(1 << 27));
    write_reg(REG_START_IMAG, pick_point(1 << 27));
    cfg_valid <= 1'b0;
  endtask

  task automatic wait_for_drain();
    in_valid <= 1'b0;
    do @(posedge clk); while (pending_results.size() != 0);
  endtask

  task automatic send_pixel(input logic [COL_W-1:0] col, input logic [ROW_W-1:0] row,
                            input logic typed, input pixel_result_t typed_res);
    while (idle_pct != 0 && $urandom_range(0, 99) < idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid     <= 1'b1;
    in_pixel_col <= col;
    in_pixel_row <= row;
    do @(posedge clk); while (in_stall);
    pending_results.push_back(typed ? typed_res : escape_count(col, row));
  endtask

  initial begin
    setting_t applied;
    int       s;
    int       k;
    applied = SET_RESET;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    foreach (directed_cases[i]) begin
      if (directed_cases[i].setting != applied) begin
        wait_for_drain();
        apply_setting(directed_cases[i].setting);
        applied = directed_cases[i].setting;
      end
      send_pixel(directed_cases[i].col, directed_cases[i].row, directed_cases[i].typed,
                 {directed_cases[i].exp_count, directed_cases[i].exp_bounded});
    end
    for (s = 0; s < RANDOM_SETTINGS; s++) begin
      wait_for_drain();
      idle_pct = (s == QUIET_SETTING) ? 0 : IDLE_PCT;
      program_random_setting();
      for (k = 0; k < ITEMS_PER_SETTING; k++) begin
        if ($urandom_range(0, 39) == 0) wait_for_drain();
        send_pixel(COL_W'($urandom), ROW_W'($urandom), 1'b0, '0);
      end
    end
    wait_for_drain();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (mismatch_count == 0 && pending_results.size() == 0) begin
      $display("escape_time_fractal_pixel test passed");
    end else begin
      $display("escape_time_fractal_pixel test failed");
    end
    $finish;
  end

  initial begin
    #(RUN_LIMIT_NS);
    $display("escape_time_fractal_pixel test failed");
    $finish;
  end

endmodule
